// File: hw/rtl/kpl_pkg.sv
// Shared types and constants for the keypad password entry lock.
package kpl_pkg;

   localparam logic [7:0] NO_KEY    = 8'hFF;
   localparam logic [7:0] KEY_ENTER = 8'h23;
   localparam logic [7:0] KEY_CLEAR = 8'h43;

   localparam logic [1:0] MODE_WELCOME = 2'd0;
   localparam logic [1:0] MODE_ENTRY   = 2'd1;
   localparam logic [1:0] MODE_SUBMIT  = 2'd2;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_START   = 3'd1;
   localparam logic [2:0] EV_STORED  = 3'd2;
   localparam logic [2:0] EV_DELETED = 3'd3;
   localparam logic [2:0] EV_GRANTED = 3'd4;
   localparam logic [2:0] EV_DENIED  = 3'd5;
   localparam logic [2:0] EV_WELCOME = 3'd6;

   localparam logic       ACT_SCAN = 1'b0;

   localparam logic [1:0] CSR_TIMEOUT_TICKS   = 2'd0;
   localparam logic [1:0] CSR_PASSWORD_CODE   = 2'd1;
   localparam logic [1:0] CSR_PASSWORD_LENGTH = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
   localparam logic [63:0] PASSWORD_RESET = 64'd4050765991979987505; // "12345678"
   localparam logic [3:0]  LENGTH_RESET = 4'd8;
   localparam logic [3:0]  PASSWORD_MAX = 4'd8;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] entry_count;
      logic [2:0] event_res;
      logic [7:0] echo_key;
   } rsp_type;

endpackage

// File: hw/rtl/kpl_ifs.sv
// Valid/ready channel interfaces for keypad requests and lock responses.
interface kpl_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] key_code;

   modport source (output valid, output action, output key_code, input ready);
   modport sink   (input valid, input action, input key_code, output ready);
endinterface

interface kpl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] entry_count;
   logic [2:0] event_res;
   logic [7:0] echo_key;

   modport source (output valid, output mode, output entry_count, output event_res,
                   output echo_key, input ready);
   modport sink   (input valid, input mode, input entry_count, input event_res,
                   input echo_key, output ready);
endinterface

// File: hw/rtl/kpl_rsp_buf.sv
// Two-entry response buffer: output register plus skid register.
module kpl_rsp_buf
   import kpl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  rsp_type push_data,
   kpl_rsp_if.source rsp
);

   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    pop;

   assign push_ready = !skid_valid_ff;
   assign push = push_valid && push_ready;
   assign pop  = head_valid_ff && rsp.ready;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // skid full means no push this cycle
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid       = head_valid_ff;
   assign rsp.mode        = head_ff.mode;
   assign rsp.entry_count = head_ff.entry_count;
   assign rsp.event_res   = head_ff.event_res;
   assign rsp.echo_key    = head_ff.echo_key;

endmodule

// File: hw/rtl/keypad_password_entry_lock.sv
// Keypad password entry lock: press detection, entry buffer, timeout and compare.
// Each accepted transaction (a keypad scan sample or a time tick) yields exactly one
// response transaction. The lock state is updated in the cycle a request is accepted
// and the response lands in a two-entry output buffer, so a request is taken every
// cycle and the response is presented from the buffer's head register; the input
// stalls only when both buffer entries are held by a stalled response channel. The
// password compare is a parallel byte compare against the held entry registers.
module keypad_password_entry_lock
   import kpl_pkg::*;
#(
   parameter int MAX_ENTRY = 9
) (
   input  logic        clock,
   input  logic        reset,
   kpl_req_if.sink     req,
   kpl_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CW = $clog2(MAX_ENTRY + 1);
   localparam int IW = (MAX_ENTRY > 1) ? $clog2(MAX_ENTRY) : 1;
   localparam int NM = (MAX_ENTRY < 8) ? MAX_ENTRY : 8;

   // configuration
   logic [15:0] timeout_ff;
   logic [63:0] password_ff;
   logic [3:0]  length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         password_ff <= PASSWORD_RESET;
         length_ff   <= LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS:   timeout_ff  <= csr_wdata[15:0];
            CSR_PASSWORD_CODE:   password_ff <= csr_wdata;
            CSR_PASSWORD_LENGTH: length_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // lock state
   logic [7:0]    last_scan_ff, last_scan_in;
   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] held_ff, held_in;
   logic [15:0]   idle_ff, idle_in;
   logic [7:0]    store_ff [MAX_ENTRY];

   logic          accept;
   logic          buf_ready;
   logic          press;
   logic          store_we;
   logic [16:0]   idle_next;
   logic [3:0]    len_eff;
   logic [NM-1:0] byte_ok;
   logic          match;
   rsp_type       result;

   assign req.ready = buf_ready;
   assign accept    = req.valid && buf_ready;

   assign len_eff = (length_ff > PASSWORD_MAX) ? PASSWORD_MAX : length_ff;

   // bytes beyond the password length always pass
   for (genvar i = 0; i < NM; i++) begin : g_cmp
      assign byte_ok[i] = (4'(i) >= len_eff) || (store_ff[i] == password_ff[8*i +: 8]);
   end

   assign match     = (5'(held_ff) == 5'(len_eff)) && (&byte_ok);
   assign press     = (req.key_code != NO_KEY) && (last_scan_ff == NO_KEY);
   assign idle_next = 17'(idle_ff) + 17'd1;

   always_comb begin
      last_scan_in     = last_scan_ff;
      mode_in          = mode_ff;
      held_in          = held_ff;
      idle_in          = idle_ff;
      store_we         = 1'b0;
      result.event_res = EV_NONE;
      result.echo_key  = 8'h00;
      if (req.action != ACT_SCAN) begin
         if (idle_next >= 17'(timeout_ff)) begin
            idle_in = 16'd0;
            if (mode_ff != MODE_WELCOME) begin
               mode_in          = MODE_WELCOME;
               held_in          = '0;
               result.event_res = EV_WELCOME;
            end
         end else begin
            idle_in = idle_next[15:0];
         end
      end else begin
         last_scan_in = req.key_code;
         if (press) begin
            idle_in = 16'd0;
            case (mode_ff)
               MODE_WELCOME: begin
                  if (req.key_code == KEY_ENTER) begin
                     mode_in          = MODE_ENTRY;
                     result.event_res = EV_START;
                  end
               end
               MODE_ENTRY: begin
                  if (req.key_code == KEY_CLEAR) begin
                     if (held_ff != '0) begin
                        held_in          = held_ff - CW'(1);
                        result.event_res = EV_DELETED;
                     end
                  end else if (req.key_code == KEY_ENTER) begin
                     mode_in          = MODE_SUBMIT;
                     held_in          = '0;
                     result.event_res = match ? EV_GRANTED : EV_DENIED;
                  end else if (held_ff < CW'(MAX_ENTRY)) begin
                     store_we         = 1'b1;
                     held_in          = held_ff + CW'(1);
                     result.event_res = EV_STORED;
                     result.echo_key  = req.key_code;
                  end
               end
               default: begin
                  mode_in          = MODE_WELCOME;
                  held_in          = '0;
                  result.event_res = EV_WELCOME;
               end
            endcase
         end
      end
      result.mode        = mode_in;
      result.entry_count = 4'(held_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scan_ff <= NO_KEY;
         mode_ff      <= MODE_WELCOME;
         held_ff      <= '0;
         idle_ff      <= 16'd0;
      end else if (accept) begin
         last_scan_ff <= last_scan_in;
         mode_ff      <= mode_in;
         held_ff      <= held_in;
         idle_ff      <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_we) begin
         store_ff[held_ff[IW-1:0]] <= req.key_code;
      end
   end

   kpl_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push_ready (buf_ready),
      .push_data  (result),
      .rsp        (rsp)
   );

endmodule

// File: hw/rtl/kpl_checker.sv
// Port-level checks for the keypad password entry lock, bound to the top level.
module kpl_checker
   import kpl_pkg::*;
#(
   parameter int MAX_ENTRY = 9
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_mode,
   input logic [3:0] rsp_entry_count,
   input logic [2:0] rsp_event_res,
   input logic [7:0] rsp_echo_key
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_entry_count) && $stable(rsp_event_res) && $stable(rsp_echo_key))
      else $error("response changed while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 5'(rsp_entry_count) <= 5'(MAX_ENTRY))
      else $error("entry count above buffer size");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != MODE_ENTRY |-> rsp_entry_count == 4'd0)
      else $error("characters held outside entry mode");

   a_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_STORED |->
         rsp_mode == MODE_ENTRY && rsp_entry_count != 4'd0)
      else $error("store reported outside entry or with empty buffer");

   a_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_STORED |-> rsp_echo_key == 8'h00)
      else $error("echo key set without a store");

endmodule

bind keypad_password_entry_lock kpl_checker #(.MAX_ENTRY(MAX_ENTRY)) u_kpl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_mode        (rsp.mode),
   .rsp_entry_count (rsp.entry_count),
   .rsp_event_res   (rsp.event_res),
   .rsp_echo_key    (rsp.echo_key)
);
